FILE: rtl/core/stq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg: types and codes for the sorted timer queue
// Request and result payloads, store entry layout, event and register codes.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam logic KIND_SCHEDULE = 1'b0;
  localparam logic KIND_TICK     = 1'b1;

  localparam logic [1:0] EV_FIRE    = 2'd0;
  localparam logic [1:0] EV_REPROG  = 2'd1;
  localparam logic [1:0] EV_REJECT  = 2'd2;

  localparam logic [1:0] REG_MIN_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_MAX_TIMEOUT = 2'd1;

  localparam logic [31:0] MIN_TIMEOUT_RESET = 32'd10;
  localparam logic [31:0] MAX_TIMEOUT_RESET = 32'd1000000;

  typedef struct packed {
    logic        kind;
    logic [63:0] now;
    logic [7:0]  handle;
    logic [31:0] delay;
    logic        oneshot;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  fired_handle;
    logic [31:0] timeout;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [63:0] expiry;
    logic [31:0] period;
    logic [7:0]  handle;
  } entry_t;

endpackage
`default_nettype wire

FILE: rtl/core/stq_timeout.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_timeout: generator timeout from the head entry, max_timeout when empty
// Clamps head-now to min_timeout near the head and saturates to 32 bits.
// ----------------------------------------------------------------------------
module stq_timeout (
  input  wire logic        empty,
  input  wire logic [63:0] head,
  input  wire logic [63:0] now,
  input  wire logic [31:0] min_timeout,
  input  wire logic [31:0] max_timeout,
  output logic      [31:0] timeout
);

  logic [63:0] near_limit;
  logic [63:0] diff;

  assign near_limit = now + {32'd0, min_timeout};
  assign diff       = head - now;

  always_comb begin
    if (empty) begin
      timeout = max_timeout;
    end else if (head <= near_limit) begin
      timeout = min_timeout;
    end else if (diff[63:32] != 32'd0) begin
      timeout = 32'hFFFF_FFFF;
    end else begin
      timeout = diff[31:0];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sorted_timer_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timer_queue: timer store sorted by expiry
// Inserts, drains due timers, re-arms periodic ones and reprograms the tick
// generator, one store entry moved per step through a single-port memory.
//
//   channel   signals                      handshake
//   command   start, busy, cmd             taken when start && !busy
//   result    result_valid, result         one-cycle strobe, no stall
//   config    cfg_valid, cfg_ready, ...    taken when cfg_valid && cfg_ready
//
// Each entry shifted (insert or remove) is read, then written; the reprogram
// step reads the head entry. An empty-store tick passes S_SCAN, S_REPROG and
// S_REPROG_RD, then strobes. A reject strobes in the next cycle and never
// sets busy. Reset clears the count and fired flags and loads the timeout
// registers with defaults; memory contents are not cleared.
// busy drops in the cycle of the last result strobe; results cannot stall.
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
  parameter int TIMER_SLOTS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire stq_pkg::cmd_t cmd,
  output logic               result_valid,
  output stq_pkg::res_t      result,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_data
);
  import stq_pkg::*;

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TIMER_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_SCAN, S_CHECK,
    S_RM_RD, S_RM_WR, S_REPROG, S_REPROG_RD
  } state_t;

  state_t           state;
  cmd_t             req;
  logic [31:0]      min_timeout;
  logic [31:0]      max_timeout;
  logic [CNT_W-1:0] count;
  logic [TIMER_SLOTS-1:0] fired;
  entry_t           new_ent;
  logic             new_fl;
  logic [IDX_W-1:0] ins_i;
  logic [CNT_W-1:0] pos;
  logic [IDX_W-1:0] rm_i;

  entry_t           mem [TIMER_SLOTS];
  entry_t           rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  logic [31:0]      timeout;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] ins_dn;
  logic [IDX_W-1:0] rm_up;
  logic [CNT_W-1:0] rm_up_cnt;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign pos_idx   = pos[IDX_W-1:0];
  assign ins_dn    = ins_i - 1'b1;
  assign rm_up     = rm_i + 1'b1;
  assign rm_up_cnt = CNT_W'(rm_i) + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  stq_timeout u_timeout (
    .empty       (count == '0),
    .head        (rd_data.expiry),
    .now         (req.now),
    .min_timeout (min_timeout),
    .max_timeout (max_timeout),
    .timeout     (timeout)
  );

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = ins_i;
    wr_data = new_ent;
    case (state)
      S_INS_RD: begin
        rd_en   = (ins_i != '0);
        rd_addr = ins_dn;
        wr_en   = (ins_i == '0);
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (rd_data.expiry >= new_ent.expiry) begin
          wr_data = rd_data;
        end
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = pos_idx;
      end
      S_RM_RD: begin
        rd_en   = 1'b1;
        rd_addr = rm_up;
      end
      S_RM_WR: begin
        wr_en   = 1'b1;
        wr_addr = rm_i;
        wr_data = rd_data;
      end
      S_REPROG: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      min_timeout  <= MIN_TIMEOUT_RESET;
      max_timeout  <= MAX_TIMEOUT_RESET;
      result_valid <= 1'b0;
      fired        <= '0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_TIMEOUT: min_timeout <= cfg_data;
          REG_MAX_TIMEOUT: max_timeout <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            req   <= cmd;
            fired <= '0;
            pos   <= '0;
            if (cmd.kind == KIND_TICK) begin
              state <= S_SCAN;
            end else if (cmd.handle == 8'd0 || count >= SLOTS_CNT) begin
              result_valid <= 1'b1;
              result       <= '{EV_REJECT, 8'd0, 32'd0, 1'b1};
            end else begin
              new_ent <= '{cmd.now + {32'd0, cmd.delay},
                           cmd.oneshot ? 32'd0 : cmd.delay, cmd.handle};
              new_fl  <= 1'b0;
              ins_i   <= count[IDX_W-1:0];
              state   <= S_INS_RD;
            end
          end
        end
        S_INS_RD: begin
          if (ins_i == '0) begin
            fired[0] <= new_fl;
            count    <= count + 1'b1;
            pos      <= '0;
            state    <= S_SCAN;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rd_data.expiry >= new_ent.expiry) begin
            fired[ins_i] <= fired[ins_dn];
            ins_i        <= ins_dn;
            state        <= S_INS_RD;
          end else begin
            fired[ins_i] <= new_fl;
            count        <= count + 1'b1;
            pos          <= '0;
            state        <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (pos >= count) begin
            state <= S_REPROG;
          end else if (fired[pos_idx]) begin
            pos <= pos + 1'b1;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (rd_data.expiry > req.now) begin
            state <= S_REPROG;
          end else begin
            result_valid <= 1'b1;
            result       <= '{EV_FIRE, rd_data.handle, 32'd0, 1'b0};
            new_ent      <= '{req.now + {32'd0, rd_data.period},
                              rd_data.period, rd_data.handle};
            new_fl       <= 1'b1;
            rm_i         <= pos_idx;
            state        <= S_RM_RD;
          end
        end
        S_RM_RD: begin
          if (rm_up_cnt >= count) begin
            count <= count - 1'b1;
            pos   <= '0;
            if (new_ent.period != 32'd0) begin
              ins_i <= IDX_W'(count - 1'b1);
              state <= S_INS_RD;
            end else begin
              state <= S_SCAN;
            end
          end else begin
            state <= S_RM_WR;
          end
        end
        S_RM_WR: begin
          fired[rm_i] <= fired[rm_up];
          rm_i        <= rm_up;
          state       <= S_RM_RD;
        end
        S_REPROG: begin
          state <= S_REPROG_RD;
        end
        S_REPROG_RD: begin
          result_valid <= 1'b1;
          result       <= '{EV_REPROG, 8'd0, timeout, 1'b1};
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= SLOTS_CNT) else $error("entry count above slot count");

  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.event_res == EV_REJECT |-> result.last && !busy)
    else $error("reject result not final");

  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.event_res == EV_FIRE |-> !result.last && busy)
    else $error("fire result marked final");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.kind == KIND_TICK |=> busy)
    else $error("tick request did not start");

endmodule
`default_nettype wire
